>>> hw/rtl/tpt_pkg.sv
// Shared constants for the TLB page table translator.
`default_nettype none
package tpt_pkg;

    // Fixed field widths of the transaction ports
    localparam int ADDR_W  = 25;
    localparam int LEGAL_W = 24;
    localparam int FRAME_W = 10;
    localparam int PHYS_W  = 16;
    localparam int SRC_W   = 2;

    // Result source codes
    localparam logic [SRC_W-1:0] SRC_ILLEGAL = 2'd0;
    localparam logic [SRC_W-1:0] SRC_TLB_HIT = 2'd1;
    localparam logic [SRC_W-1:0] SRC_PT_HIT  = 2'd2;
    localparam logic [SRC_W-1:0] SRC_FAULT   = 2'd3;

endpackage
`default_nettype wire

>>> hw/rtl/tpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/tpt_div.sv
// Quotient and remainder of a page number by a constant divisor.
`default_nettype none
module tpt_div #(
    parameter int DIV_W   = 18,
    parameter int DIVISOR = 1024,
    parameter int Q_W     = 8,
    parameter int R_W     = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    output logic                  o_valid,
    output logic      [Q_W-1:0]   o_quot,
    output logic      [R_W-1:0]   o_rem
);

    localparam bit IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

    generate
        if (IS_POW2) begin : g_pow2
            // Power of two: shift and mask, registered
            localparam int               SHIFT = $clog2(DIVISOR);
            localparam logic [DIV_W-1:0] MASK  = DIV_W'(DIVISOR - 1);

            logic             r_valid;
            logic [Q_W-1:0]   r_quot;
            logic [R_W-1:0]   r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid <= 1'b0;
                end else if (i_start) begin
                    r_valid <= 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_quot <= Q_W'(i_dividend >> SHIFT);
                    r_rem  <= R_W'(i_dividend & MASK);
                end
            end

            assign o_valid = r_valid;
            assign o_quot  = r_quot;
            assign o_rem   = r_rem;
        end else begin : g_recip
            // Other divisors: quotient by reciprocal multiply, remainder by
            // multiplying back from the registered quotient. The rounded-up reciprocal with
            // DIV_W + clog2(DIVISOR) fraction bits is exact for any dividend.
            localparam int               L_W     = $clog2(DIVISOR);
            localparam int               SH      = DIV_W + L_W;
            localparam int               M_W     = DIV_W + 2;
            localparam int               P_W     = DIV_W + M_W;
            localparam logic [63:0]      RECIP   = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1)
                                                   / 64'(DIVISOR);
            localparam logic [M_W-1:0]   RECIP_M = M_W'(RECIP);
            localparam logic [DIV_W-1:0] DIV_X   = DIV_W'(DIVISOR);

            logic             r_stage;
            logic             r_valid;
            logic [DIV_W-1:0] r_x;
            logic [DIV_W-1:0] r_q;
            logic [Q_W-1:0]   r_quot;
            logic [R_W-1:0]   r_rem;
            logic [P_W-1:0]   prod;

            assign prod = P_W'(i_dividend) * P_W'(RECIP_M);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stage <= 1'b0;
                    r_valid <= 1'b0;
                end else begin
                    r_stage <= i_start;
                    if (i_start) begin
                        r_valid <= 1'b0;
                    end else if (r_stage) begin
                        r_valid <= 1'b1;
                    end
                end
            end

            // Stage one: quotient; stage two: remainder from the quotient
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_x <= i_dividend;
                    r_q <= DIV_W'(prod >> SH);
                end
                if (r_stage) begin
                    r_quot <= Q_W'(r_q);
                    r_rem  <= R_W'(DIV_W'(r_x - r_q * DIV_X));
                end
            end

            assign o_valid = r_valid;
            assign o_quot  = r_quot;
            assign o_rem   = r_rem;
        end
    endgenerate

endmodule
`default_nettype wire

>>> hw/rtl/tpt_way_sel.sv
// Way match, victim choice and LRU rank update for one TLB set.
`default_nettype none
module tpt_way_sel #(
    parameter int WAYS   = 4,
    parameter int TAG_W  = 8,
    parameter int RANK_W = 2,
    parameter int WAY_W  = 2
) (
    input  wire logic [WAYS-1:0]             i_valid,
    input  wire logic [WAYS-1:0][TAG_W-1:0]  i_tags,
    input  wire logic [WAYS-1:0][RANK_W-1:0] i_ranks,
    input  wire logic [TAG_W-1:0]            i_tag,
    output logic                             o_hit,
    output logic      [WAY_W-1:0]            o_way,
    output logic      [WAYS-1:0][RANK_W-1:0] o_ranks
);

    logic             free;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] lru_way;
    logic [RANK_W-1:0] old_rank;

    // Lowest matching way, lowest invalid way, rank-zero way
    always_comb begin
        o_hit    = 1'b0;
        free     = 1'b0;
        hit_way  = '0;
        free_way = '0;
        lru_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_valid[w] && i_tags[w] == i_tag) begin
                o_hit   = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!i_valid[w]) begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
            if (i_ranks[w] == '0) begin
                lru_way = WAY_W'(w);
            end
        end
        if (o_hit) begin
            o_way = hit_way;
        end else if (free) begin
            o_way = free_way;
        end else begin
            o_way = lru_way;
        end
    end

    // Chosen way becomes most recently used
    always_comb begin
        old_rank = i_ranks[o_way];
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == o_way) begin
                o_ranks[w] = RANK_W'(WAYS - 1);
            end else if (i_ranks[w] > old_rank) begin
                o_ranks[w] = i_ranks[w] - 1'b1;
            end else begin
                o_ranks[w] = i_ranks[w];
            end
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/tlb_page_table_translator.sv
// Top level: set-associative TLB in front of a flat page table.
//
// Translates a virtual address into a physical address. A transaction is
// taken when start is high and busy is low; its result appears on
// o_paddr/o_source for exactly one cycle with o_valid high, and the
// receiver cannot stall it. An illegal address (bit 24 set) gives its result
// in the next cycle and leaves busy low. A legal address splits the page
// number into set, tag and page-table index, then does one read of the TLB
// set row and the page-table entry and one write-back; busy stays high
// through the split (S_DIV) and the write-back (S_LOOK), and the split
// waits for the reciprocal divider's second stage unless TLB_SETS and
// PT_ENTRIES are powers of two. After reset busy stays high while both
// memories are cleared one entry per cycle over max(TLB_SETS, PT_ENTRIES)
// addresses.
`default_nettype none
module tlb_page_table_translator
    import tpt_pkg::*;
#(
    parameter int TLB_SETS    = 1024,
    parameter int TLB_WAYS    = 4,
    parameter int PT_ENTRIES  = 262144,
    parameter int OFFSET_BITS = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [ADDR_W-1:0]   i_virt_address,
    input  wire logic [FRAME_W-1:0]  i_fault_ppn,
    output logic                     o_valid,
    output logic      [PHYS_W-1:0]   o_paddr,
    output logic      [SRC_W-1:0]    o_source
);

    localparam int VPN_W      = LEGAL_W - OFFSET_BITS;
    localparam int SET_W      = (TLB_SETS > 1) ? $clog2(TLB_SETS) : 1;
    localparam int SET_FLOOR  = $clog2(TLB_SETS + 1) - 1;
    localparam int TAG_W      = (VPN_W > SET_FLOOR) ? VPN_W - SET_FLOOR : 1;
    localparam int PTI_W      = $clog2(PT_ENTRIES);
    localparam int WAY_W      = (TLB_WAYS > 1) ? $clog2(TLB_WAYS) : 1;
    localparam int RANK_W     = WAY_W;
    localparam int ROW_W      = TLB_WAYS * (1 + TAG_W + FRAME_W + RANK_W);
    localparam int PT_W       = 1 + FRAME_W;
    localparam int CLR_N      = (TLB_SETS > PT_ENTRIES) ? TLB_SETS : PT_ENTRIES;
    localparam int CLR_W      = $clog2(CLR_N) + 1;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_DIV   = 4'b0100,
        S_LOOK  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [CLR_W-1:0]        r_clr, n_clr;
    logic [OFFSET_BITS-1:0]  r_offset;
    logic [FRAME_W-1:0]      r_fppn;
    logic                    r_ovalid, n_ovalid;
    logic [PHYS_W-1:0]       r_phys, n_phys;
    logic [SRC_W-1:0]        r_src, n_src;

    logic                    accept;
    logic                    legal;
    logic                    split_go;

    logic                    set_ok, pti_ok;
    logic [TAG_W-1:0]        tag;
    logic [SET_W-1:0]        set_idx;
    logic [PTI_W-1:0]        pti;

    logic                    tlb_we, tlb_re;
    logic [SET_W-1:0]        tlb_waddr;
    logic [ROW_W-1:0]        tlb_wdata, tlb_rdata;
    logic                    pt_we, pt_re;
    logic [PTI_W-1:0]        pt_waddr;
    logic [PT_W-1:0]         pt_wdata, pt_rdata;

    logic [TLB_WAYS-1:0]                 rd_valid, wr_valid;
    logic [TLB_WAYS-1:0][TAG_W-1:0]      rd_tags, wr_tags;
    logic [TLB_WAYS-1:0][FRAME_W-1:0]    rd_frames, wr_frames;
    logic [TLB_WAYS-1:0][RANK_W-1:0]     rd_ranks, new_ranks, clr_ranks;

    logic                    hit;
    logic [WAY_W-1:0]        sel_way;
    logic [FRAME_W-1:0]      frame;
    logic [SRC_W-1:0]        look_src;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign legal    = !i_virt_address[LEGAL_W];
    assign split_go = accept && legal;

    // Index split: set and tag from the page number, page-table index
    tpt_div #(
        .DIV_W   (VPN_W),
        .DIVISOR (TLB_SETS),
        .Q_W     (TAG_W),
        .R_W     (SET_W)
    ) u_set_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (split_go),
        .i_dividend (i_virt_address[LEGAL_W-1:OFFSET_BITS]),
        .o_valid    (set_ok),
        .o_quot     (tag),
        .o_rem      (set_idx)
    );

    tpt_div #(
        .DIV_W   (VPN_W),
        .DIVISOR (PT_ENTRIES),
        .Q_W     (1),
        .R_W     (PTI_W)
    ) u_pti_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (split_go),
        .i_dividend (i_virt_address[LEGAL_W-1:OFFSET_BITS]),
        .o_valid    (pti_ok),
        .o_quot     (),
        .o_rem      (pti)
    );

    // TLB set rows and page-table entries
    tpt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TLB_SETS)
    ) u_tlb_ram (
        .i_clk   (i_clk),
        .i_we    (tlb_we),
        .i_waddr (tlb_waddr),
        .i_wdata (tlb_wdata),
        .i_re    (tlb_re),
        .i_raddr (set_idx),
        .o_rdata (tlb_rdata)
    );

    tpt_ram #(
        .WIDTH (PT_W),
        .DEPTH (PT_ENTRIES)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (pt_waddr),
        .i_wdata (pt_wdata),
        .i_re    (pt_re),
        .i_raddr (pti),
        .o_rdata (pt_rdata)
    );

    assign {rd_valid, rd_tags, rd_frames, rd_ranks} = tlb_rdata;

    // Hit search, victim choice and LRU update on the row just read
    tpt_way_sel #(
        .WAYS   (TLB_WAYS),
        .TAG_W  (TAG_W),
        .RANK_W (RANK_W),
        .WAY_W  (WAY_W)
    ) u_way_sel (
        .i_valid (rd_valid),
        .i_tags  (rd_tags),
        .i_ranks (rd_ranks),
        .i_tag   (tag),
        .o_hit   (hit),
        .o_way   (sel_way),
        .o_ranks (new_ranks)
    );

    // Reset ranks: way w has rank w
    always_comb begin
        for (int w = 0; w < TLB_WAYS; w++) begin
            clr_ranks[w] = RANK_W'(w);
        end
    end

    // Frame and source of a looked-up transaction
    always_comb begin
        if (hit) begin
            frame    = rd_frames[sel_way];
            look_src = SRC_TLB_HIT;
        end else if (pt_rdata[PT_W-1]) begin
            frame    = pt_rdata[FRAME_W-1:0];
            look_src = SRC_PT_HIT;
        end else begin
            frame    = r_fppn;
            look_src = SRC_FAULT;
        end
    end

    // Updated set row
    always_comb begin
        wr_valid  = rd_valid;
        wr_tags   = rd_tags;
        wr_frames = rd_frames;
        wr_valid[sel_way]  = 1'b1;
        wr_tags[sel_way]   = tag;
        wr_frames[sel_way] = frame;
    end

    // Sequencer: clear pass, accept, index split, read, write-back
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_ovalid  = 1'b0;
        n_phys    = r_phys;
        n_src     = r_src;
        tlb_we    = 1'b0;
        tlb_re    = 1'b0;
        tlb_waddr = set_idx;
        tlb_wdata = {wr_valid, wr_tags, wr_frames, new_ranks};
        pt_we     = 1'b0;
        pt_re     = 1'b0;
        pt_waddr  = pti;
        pt_wdata  = {1'b1, r_fppn};
        unique case (r_state)
            S_CLEAR: begin
                tlb_we    = r_clr < CLR_W'(TLB_SETS);
                tlb_waddr = r_clr[SET_W-1:0];
                tlb_wdata = {{TLB_WAYS{1'b0}}, {(TLB_WAYS * (TAG_W + FRAME_W)){1'b0}},
                             clr_ranks};
                pt_we     = r_clr < CLR_W'(PT_ENTRIES);
                pt_waddr  = r_clr[PTI_W-1:0];
                pt_wdata  = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == CLR_W'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (legal) begin
                        n_state = S_DIV;
                    end else begin
                        n_ovalid = 1'b1;
                        n_phys   = '0;
                        n_src    = SRC_ILLEGAL;
                    end
                end
            end
            S_DIV: begin
                if (set_ok && pti_ok) begin
                    tlb_re  = 1'b1;
                    pt_re   = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                tlb_we   = 1'b1;
                pt_we    = !hit && !pt_rdata[PT_W-1];
                n_ovalid = 1'b1;
                n_phys   = PHYS_W'({frame, r_offset});
                n_src    = look_src;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_phys <= n_phys;
        r_src  <= n_src;
        if (accept) begin
            r_offset <= i_virt_address[OFFSET_BITS-1:0];
            r_fppn   <= i_fault_ppn;
        end
    end

    assign o_valid  = r_ovalid;
    assign o_paddr  = r_phys;
    assign o_source = r_src;

endmodule
`default_nettype wire

>>> sim/tlb_page_table_translator_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the TLB page table translator: directed table plus random traffic.
module tlb_page_table_translator_test;
    import tpt_pkg::*;

    // Geometry at the default parameters
    localparam int OFS_W      = 6;
    localparam int SET_W      = 10;
    localparam int TAG_W      = 8;
    localparam int VPN_W      = LEGAL_W - OFS_W;
    localparam int SETS       = 1 << SET_W;
    localparam int WAYS       = 4;
    localparam int PT_SIZE    = 1 << VPN_W;
    localparam int DIR_ROWS   = 18;
    localparam int RAND_ITEMS = 1450;
    localparam int TAIL_WAIT  = 16;
    localparam int CYCLE_CAP  = 1_000_000;

    typedef struct packed {
        logic [PHYS_W-1:0] phys;
        logic [SRC_W-1:0]  src;
    } t_xlat;

    typedef struct {
        logic [ADDR_W-1:0]  va;
        logic [FRAME_W-1:0] ppn;
        bit                 typed;
        t_xlat              res;
    } t_dir_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [ADDR_W-1:0]  i_virt_address = '0;
    logic [FRAME_W-1:0] i_fault_ppn = '0;
    logic               busy;
    logic               o_valid;
    logic [PHYS_W-1:0]  o_paddr;
    logic [SRC_W-1:0]   o_source;

    // Shadow copy of the translation state
    bit                 tlb_valid [SETS][WAYS];
    logic [TAG_W-1:0]   tlb_tag   [SETS][WAYS];
    logic [FRAME_W-1:0] tlb_frame [SETS][WAYS];
    logic [1:0]         lru_rank  [SETS][WAYS];
    bit                 pt_valid  [PT_SIZE];
    logic [FRAME_W-1:0] pt_frame  [PT_SIZE];

    t_xlat    pending_xlat [$];
    t_xlat    want;
    t_dir_row dir_rows [DIR_ROWS];
    int       fail_count = 0;
    int       cycles = 0;

    tlb_page_table_translator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_virt_address (i_virt_address),
        .i_fault_ppn    (i_fault_ppn),
        .o_valid        (o_valid),
        .o_paddr        (o_paddr),
        .o_source       (o_source)
    );

    always #5 i_clk = ~i_clk;

    // Run limit, sized to cover the post-reset clearing pass
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] va_of(input logic [TAG_W-1:0] tag,
                                                input logic [SET_W-1:0] set_i,
                                                input logic [OFS_W-1:0] ofs);
        return {1'b0, tag, set_i, ofs};
    endfunction

    // Translate one address and update the shadow TLB, LRU ranks and page table
    function automatic t_xlat translate_va(input logic [ADDR_W-1:0] va,
                                           input logic [FRAME_W-1:0] ppn);
        t_xlat              res;
        logic [OFS_W-1:0]   ofs;
        logic [VPN_W-1:0]   vpn;
        logic [SET_W-1:0]   set_i;
        logic [TAG_W-1:0]   tag;
        logic [FRAME_W-1:0] frame;
        logic [1:0]         old_rank;
        int                 way;
        bit                 hit;
        bit                 found;

        res.phys = '0;
        res.src  = SRC_ILLEGAL;
        if (va[LEGAL_W])
            return res;

        ofs   = va[OFS_W-1:0];
        vpn   = va[LEGAL_W-1:OFS_W];
        set_i = vpn[SET_W-1:0];
        tag   = vpn[VPN_W-1:SET_W];
        hit   = 1'b0;
        found = 1'b0;
        way   = 0;

        for (int w = 0; w < WAYS; w++) begin
            if (!hit && tlb_valid[set_i][w] && tlb_tag[set_i][w] == tag) begin
                hit = 1'b1;
                way = w;
            end
        end

        if (hit) begin
            frame   = tlb_frame[set_i][way];
            res.src = SRC_TLB_HIT;
        end else begin
            // victim: lowest invalid way, else the LRU way
            for (int w = 0; w < WAYS; w++) begin
                if (!found && !tlb_valid[set_i][w]) begin
                    found = 1'b1;
                    way = w;
                end
            end
            if (!found) begin
                for (int w = WAYS - 1; w >= 0; w--)
                    if (lru_rank[set_i][w] == 0)
                        way = w;
            end
            if (pt_valid[vpn]) begin
                frame   = pt_frame[vpn];
                res.src = SRC_PT_HIT;
            end else begin
                pt_valid[vpn] = 1'b1;
                pt_frame[vpn] = ppn;
                frame   = ppn;
                res.src = SRC_FAULT;
            end
            tlb_valid[set_i][way] = 1'b1;
            tlb_tag[set_i][way]   = tag;
            tlb_frame[set_i][way] = frame;
        end

        // move the used way to the most recent rank
        old_rank = lru_rank[set_i][way];
        for (int w = 0; w < WAYS; w++)
            if (lru_rank[set_i][w] > old_rank)
                lru_rank[set_i][w] = lru_rank[set_i][w] - 1'b1;
        lru_rank[set_i][way] = 2'(WAYS - 1);

        res.phys = {frame, ofs};
        return res;
    endfunction

    // Present one transaction and hold it until accepted; start stays high afterward
    task automatic issue(input logic [ADDR_W-1:0] va, input logic [FRAME_W-1:0] ppn,
                         input bit typed, input t_xlat typed_res);
        t_xlat pred;
        i_virt_address <= va;
        i_fault_ppn    <= ppn;
        start          <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        pred = translate_va(va, ppn);
        pending_xlat.push_back(typed ? typed_res : pred);
    endtask

    // Random address: mostly a small hot set of pages so hits, evictions and
    // page-table hits all occur; the rest is full-range legal and illegal noise
    task automatic pick_access(output logic [ADDR_W-1:0] va);
        logic [SET_W-1:0] hot_sets [5];
        logic [TAG_W-1:0] tag;
        int               sel;

        hot_sets = '{10'd0, 10'd1, 10'd5, 10'd512, 10'd1023};
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            va = 25'h1000000 | 25'($urandom_range(0, 16777215));
        end else if (sel < 22) begin
            va = 25'($urandom_range(0, 16777215));
        end else begin
            tag = ($urandom_range(0, 15) == 0) ? 8'hFF : 8'($urandom_range(0, 6));
            va  = va_of(tag, hot_sets[$urandom_range(0, 4)], 6'($urandom));
        end
    endtask

    // Result checker: every strobe must match the oldest outstanding transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_xlat.size() == 0) begin
                $error("unexpected result: paddr %h source %0d",
                       o_paddr, o_source);
                fail_count++;
            end else begin
                want = pending_xlat.pop_front();
                if (o_paddr !== want.phys) begin
                    $error("paddr: expected %h, actual %h", want.phys, o_paddr);
                    fail_count++;
                end
                if (o_source !== want.src) begin
                    $error("source: expected %0d, actual %0d", want.src, o_source);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [ADDR_W-1:0]  va;
        logic [FRAME_W-1:0] ppn;
        int                 sent;
        int                 burst;
        int                 gap;
        bit                 drained;

        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++)
                lru_rank[s][w] = 2'(w);

        dir_rows = '{
            '{va_of(0, 0, 0),          10'h3FF, 1'b1, '{16'hFFC0, SRC_FAULT}},
            '{va_of(0, 0, 63),         10'h000, 1'b1, '{16'hFFFF, SRC_TLB_HIT}},
            '{25'h0FFFFFF,             10'h2AA, 1'b1, '{16'hAABF, SRC_FAULT}},
            '{25'h1000000,             10'h3FF, 1'b1, '{16'h0000, SRC_ILLEGAL}},
            '{25'h1FFFFFF,             10'h155, 1'b1, '{16'h0000, SRC_ILLEGAL}},
            '{25'h0FFFFFF,             10'h000, 1'b1, '{16'hAABF, SRC_TLB_HIT}},
            '{va_of(0, 5, 1),          10'h001, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(1, 5, 2),          10'h002, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(2, 5, 3),          10'h004, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(3, 5, 4),          10'h008, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(4, 5, 5),          10'h010, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(0, 5, 6),          10'h3FF, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(2, 5, 7),          10'h3FF, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(1, 5, 8),          10'h3FF, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(3, 5, 9),          10'h3FF, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(8'hFF, 0, 0),      10'h200, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{va_of(0, 10'h3FF, 0),    10'h0FF, 1'b0, '{16'h0000, SRC_ILLEGAL}},
            '{25'h1000000 | va_of(0, 5, 7), 10'h3FF, 1'b1, '{16'h0000, SRC_ILLEGAL}}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, back to back
        foreach (dir_rows[r])
            issue(dir_rows[r].va, dir_rows[r].ppn, dir_rows[r].typed, dir_rows[r].res);

        // Random bursts with random gaps; one full drain halfway through
        sent    = 0;
        drained = 1'b0;
        while (sent < RAND_ITEMS) begin
            burst = $urandom_range(1, 16);
            for (int k = 0; k < burst && sent < RAND_ITEMS; k++) begin
                pick_access(va);
                ppn = 10'($urandom);
                issue(va, ppn, 1'b0, '0);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (!drained && sent >= RAND_ITEMS / 2) begin
                start <= 1'b0;
                do
                    @(posedge i_clk);
                while (pending_xlat.size() != 0);
                drained = 1'b1;
            end else if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        // Wind down
        start <= 1'b0;
        while (pending_xlat.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (pending_xlat.size() != 0)
            fail_count++;

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tpt_pkg.sv
hw/rtl/tpt_ram.sv
hw/rtl/tpt_div.sv
hw/rtl/tpt_way_sel.sv
hw/rtl/tlb_page_table_translator.sv
sim/tlb_page_table_translator_test.sv
